[hw/rtl/contrast_autofocus_hill_climb_defines.svh]
// assertion macros for the autofocus rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef CONTRAST_AUTOFOCUS_HILL_CLIMB_DEFINES_SVH
`define CONTRAST_AUTOFOCUS_HILL_CLIMB_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property checked on every edge outside reset
`define CAF_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("autofocus assertion failed");

// condition in one cycle implies an outcome in the next
`define CAF_ASSERT_NEXT(name, clk, rst, cond, outcome) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (outcome)) \
    else $error("autofocus assertion failed");

`else

`define CAF_ASSERT(name, clk, rst, prop)
`define CAF_ASSERT_NEXT(name, clk, rst, cond, outcome)

`endif

`endif

[hw/rtl/caf_pkg.sv]
// shared types, constants and grid helpers for the contrast autofocus block
// no dependencies
package caf_pkg;

  localparam int GRID_COLS    = 12;
  localparam int GRID_BLOCKS  = 96;
  localparam int MAX_LENS_POS = 1023;

  localparam int SUM_W    = 39;
  localparam int POS_W    = 12;
  localparam int STEP_W   = 8;
  localparam int FRAMES_W = 9;
  localparam int PADDR_W  = 5;

  localparam logic signed [POS_W-1:0] LENS_MAX = POS_W'(MAX_LENS_POS);
  localparam logic [FRAMES_W-1:0]     FRAMES_MAX = '1;

  // request kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_CANCEL = 2'd2;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_WIN_LEFT       = 3'd0;
  localparam logic [2:0] REG_WIN_TOP        = 3'd1;
  localparam logic [2:0] REG_WIN_WIDTH      = 3'd2;
  localparam logic [2:0] REG_WIN_HEIGHT     = 3'd3;
  localparam logic [2:0] REG_COARSE_STEP    = 3'd4;
  localparam logic [2:0] REG_FINE_STEP      = 3'd5;
  localparam logic [2:0] REG_STARTUP_FRAMES = 3'd6;

  typedef struct packed {
    logic [3:0] win_left;
    logic [2:0] win_top;
    logic [3:0] win_width;
    logic [3:0] win_height;
    logic [6:0] coarse_step;
    logic [6:0] fine_step;
    logic [7:0] startup_frames;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        in_win;
    logic [31:0] contrast;
    logic        last;
  } item_t;

  // row = idx / 12 via reciprocal 171/2048, exact for 7-bit indexes
  function automatic logic [3:0] grid_row(input logic [6:0] idx);
    logic [14:0] prod;
    prod = 15'(idx) * 15'd171;
    return prod[14:11];
  endfunction

  function automatic logic [3:0] grid_col(input logic [6:0] idx);
    logic [3:0] row;
    logic [6:0] base;
    row  = grid_row(idx);
    base = 7'({row, 3'b000}) + 7'({row, 2'b00});
    return 4'(idx - base);
  endfunction

endpackage

[hw/rtl/contrast_autofocus_hill_climb.sv]
// top level of the contrast autofocus hill-climb block
// depends on caf_pkg, caf_regs, caf_blk_in and caf_climb
//
//  channel   dir  handshake          contents
//  s_*       in   tvalid / tready    block sample or trigger request
//  m_*       out  tvalid / tready    one focus result per frame
//  apb       in   psel / penable     configuration registers at 4*index
//
// one request is taken per cycle unless a waiting last-block sample holds the input
// register; a request passes through the input register, and the frame step for a
// last-block sample is registered into the result register that drives m_tvalid.
// a last-block sample waits in the input register while the result register
// still holds an untaken result; other requests keep flowing.
// synchronous reset restores register defaults and clears all scan state.
module contrast_autofocus_hill_climb (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [39:0]                 s_tdata,  // block_index[6:0], contrast[38:7], zero
  input  logic [1:0]                  s_tuser,  // kind[1:0]
  input  logic                        s_tlast,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [63:0]                 m_tdata,  // reported_position[11:0],
                                                // new_position[23:12],
                                                // figure_of_merit[62:24],
                                                // scan_active[63]
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [caf_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  caf_pkg::cfg_t  cfg;
  caf_pkg::item_t item;
  logic           item_valid;
  logic           advance;

  caf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  caf_blk_in u_blk_in (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .kind        (s_tuser),
    .block_index (s_tdata[6:0]),
    .contrast    (s_tdata[38:7]),
    .last_block  (s_tlast),
    .advance     (advance),
    .item_valid  (item_valid),
    .item        (item)
  );

  caf_climb u_climb (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata)
  );

endmodule

[hw/rtl/caf_regs.sv]
// configuration registers behind a small apb-style port
// depends on caf_pkg
module caf_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [caf_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output caf_pkg::cfg_t               cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.win_left       <= 4'd3;
      cfg.win_top        <= 3'd2;
      cfg.win_width      <= 4'd6;
      cfg.win_height     <= 4'd4;
      cfg.coarse_step    <= 7'd31;
      cfg.fine_step      <= 7'd4;
      cfg.startup_frames <= 8'd30;
    end else if (wr_en) begin
      unique case (reg_idx)
        caf_pkg::REG_WIN_LEFT:       cfg.win_left       <= pwdata[3:0];
        caf_pkg::REG_WIN_TOP:        cfg.win_top        <= pwdata[2:0];
        caf_pkg::REG_WIN_WIDTH:      cfg.win_width      <= pwdata[3:0];
        caf_pkg::REG_WIN_HEIGHT:     cfg.win_height     <= pwdata[3:0];
        caf_pkg::REG_COARSE_STEP:    cfg.coarse_step    <= pwdata[6:0];
        caf_pkg::REG_FINE_STEP:      cfg.fine_step      <= pwdata[6:0];
        caf_pkg::REG_STARTUP_FRAMES: cfg.startup_frames <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      caf_pkg::REG_WIN_LEFT:       prdata = 32'(cfg.win_left);
      caf_pkg::REG_WIN_TOP:        prdata = 32'(cfg.win_top);
      caf_pkg::REG_WIN_WIDTH:      prdata = 32'(cfg.win_width);
      caf_pkg::REG_WIN_HEIGHT:     prdata = 32'(cfg.win_height);
      caf_pkg::REG_COARSE_STEP:    prdata = 32'(cfg.coarse_step);
      caf_pkg::REG_FINE_STEP:      prdata = 32'(cfg.fine_step);
      caf_pkg::REG_STARTUP_FRAMES: prdata = 32'(cfg.startup_frames);
      default:                     prdata = '0;
    endcase
  end

endmodule

[hw/rtl/caf_blk_in.sv]
// input register: takes a request and decodes window membership of its block
// depends on caf_pkg
module caf_blk_in (
  input  logic           clk,
  input  logic           rst,
  input  caf_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     kind,
  input  logic [6:0]     block_index,
  input  logic [31:0]    contrast,
  input  logic           last_block,
  input  logic           advance,
  output logic           item_valid,
  output caf_pkg::item_t item
);

  logic       accept;
  logic       item_valid_next;
  logic [3:0] row;
  logic [3:0] col;
  logic [4:0] col_end;
  logic [4:0] row_end;
  logic       in_grid;
  logic       in_win;

  assign in_ready = !item_valid || advance;
  assign accept   = in_valid && in_ready;

  // window is clipped by the grid since col never exceeds it and in_grid drops rows past it
  always_comb begin
    row     = caf_pkg::grid_row(block_index);
    col     = caf_pkg::grid_col(block_index);
    col_end = 5'(cfg.win_left) + 5'(cfg.win_width);
    row_end = 5'(cfg.win_top) + 5'(cfg.win_height);
    in_grid = 32'(block_index) < 32'(caf_pkg::GRID_BLOCKS);
    in_win  = in_grid && (col >= cfg.win_left) && (5'(col) < col_end)
              && (row >= 4'(cfg.win_top)) && (5'(row) < row_end);
  end

  always_comb begin
    item_valid_next = item_valid;
    if (accept) begin
      item_valid_next = 1'b1;
    end else if (advance) begin
      item_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= item_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.kind     <= kind;
      item.in_win   <= in_win;
      item.contrast <= contrast;
      item.last     <= last_block;
    end
  end

endmodule

[hw/rtl/caf_climb.sv]
// window accumulation, hill-climb frame step and result register
// depends on caf_pkg and the assertion macro header
`include "contrast_autofocus_hill_climb_defines.svh"

module caf_climb (
  input  logic           clk,
  input  logic           rst,
  input  caf_pkg::cfg_t  cfg,
  input  logic           item_valid,
  input  caf_pkg::item_t item,
  output logic           advance,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [63:0]    out_data
);

  localparam int SW = caf_pkg::SUM_W;
  localparam int PW = caf_pkg::POS_W;
  localparam int TW = caf_pkg::STEP_W;
  localparam int FW = caf_pkg::FRAMES_W;

  logic        [SW-1:0] window_sum, window_sum_next;
  logic        [SW-1:0] best_sum, best_sum_next;
  logic signed [PW-1:0] best_position, best_position_next;
  logic signed [PW-1:0] lens_position, lens_position_next;
  logic signed [TW-1:0] step_size, step_size_next;
  logic        [1:0]    retries_left, retries_left_next;
  logic                 scanning, scanning_next;
  logic        [FW-1:0] frames_seen, frames_seen_next;
  logic                 out_valid_next;

  logic                 is_frame;
  logic                 fire_frame;
  logic        [SW:0]   acc_raw;
  logic        [SW-1:0] acc;
  logic        [SW+3:0] sum10, best9;
  logic        [SW+2:0] sum5, best4;
  logic                 passed;
  logic                 drop;
  logic                 new_best;
  logic        [SW-1:0] best1;
  logic signed [PW-1:0] bpos1;
  logic                 at_end;
  logic                 done;
  logic        [1:0]    retries_c;
  logic signed [TW-1:0] step_c;
  logic signed [PW-1:0] step_ext;
  logic        [TW-1:0] mag;
  logic signed [TW-1:0] step_odd;
  logic signed [TW-1:0] half;

  // frame step results
  logic        [SW-1:0] f_best;
  logic signed [PW-1:0] f_bpos;
  logic signed [PW-1:0] f_lens;
  logic signed [TW-1:0] f_step;
  logic        [1:0]    f_retries;
  logic                 f_scanning;
  logic        [FW-1:0] f_frames;

  assign is_frame   = (item.kind == caf_pkg::KIND_SAMPLE) && item.last;
  assign advance    = item_valid && (!is_frame || !out_valid || out_ready);
  assign fire_frame = advance && is_frame;

  // saturating window accumulation
  always_comb begin
    acc_raw = {1'b0, window_sum} + (SW+1)'(item.contrast);
    if (!item.in_win) begin
      acc = window_sum;
    end else if (acc_raw[SW]) begin
      acc = '1;
    end else begin
      acc = acc_raw[SW-1:0];
    end
  end

  // threshold tests against the old best; equivalent since a new best never trips them
  always_comb begin
    sum10    = (SW+4)'({acc, 3'b000}) + (SW+4)'({acc, 1'b0});
    best9    = (SW+4)'({best_sum, 3'b000}) + (SW+4)'(best_sum);
    sum5     = (SW+3)'({acc, 2'b00}) + (SW+3)'(acc);
    best4    = (SW+3)'({best_sum, 2'b00});
    passed   = sum10 < best9;
    drop     = sum5 < best4;
    new_best = acc >= best_sum;
    best1    = new_best ? acc : best_sum;
    bpos1    = new_best ? lens_position : best_position;
  end

  // one climbing step, reversing at the lens ends until the retries run out
  always_comb begin
    at_end    = step_size[TW-1] ? (lens_position <= 0) : (lens_position >= caf_pkg::LENS_MAX);
    retries_c = retries_left;
    step_c    = step_size;
    done      = passed;
    if (!passed && at_end) begin
      if (retries_left <= 2'd1) begin
        retries_c = '0;
        done      = 1'b1;
      end else begin
        retries_c = retries_left - 2'd1;
        step_c    = -step_size;
      end
    end
    step_ext = {{(PW-TW){step_c[TW-1]}}, step_c};
    mag      = step_c[TW-1] ? TW'(-step_c) : TW'(step_c);
    // divide by two rounding toward zero
    step_odd = step_c[TW-1] ? step_c + TW'(1) : step_c;
    half     = step_odd >>> 1;
  end

  always_comb begin
    f_best     = best1;
    f_bpos     = bpos1;
    f_lens     = lens_position;
    f_step     = step_size;
    f_retries  = retries_left;
    f_scanning = scanning;
    if (scanning) begin
      f_retries = retries_c;
      f_step    = step_c;
      if (!done) begin
        f_lens = lens_position + step_ext;
      end else if (mag > {1'b0, cfg.fine_step}) begin
        // passed the peak with a coarse step: back up and refine
        f_lens    = bpos1 + step_ext;
        f_step    = -half;
        f_retries = 2'd1;
        f_best    = '0;
      end else begin
        f_lens     = bpos1;
        f_scanning = 1'b0;
      end
    end else if (drop || (frames_seen == FW'(cfg.startup_frames))) begin
      f_best     = '0;
      f_step     = TW'(cfg.coarse_step);
      f_retries  = 2'd2;
      f_scanning = 1'b1;
    end
    f_frames = (frames_seen == caf_pkg::FRAMES_MAX) ? frames_seen : frames_seen + FW'(1);
  end

  always_comb begin
    window_sum_next    = window_sum;
    best_sum_next      = best_sum;
    best_position_next = best_position;
    lens_position_next = lens_position;
    step_size_next     = step_size;
    retries_left_next  = retries_left;
    scanning_next      = scanning;
    frames_seen_next   = frames_seen;
    if (advance) begin
      unique case (item.kind)
        caf_pkg::KIND_START: begin
          best_sum_next     = '0;
          step_size_next    = TW'(cfg.coarse_step);
          retries_left_next = 2'd2;
          scanning_next     = 1'b1;
        end
        caf_pkg::KIND_CANCEL: begin
          scanning_next = 1'b0;
        end
        caf_pkg::KIND_SAMPLE: begin
          if (item.last) begin
            window_sum_next    = '0;
            best_sum_next      = f_best;
            best_position_next = f_bpos;
            lens_position_next = f_lens;
            step_size_next     = f_step;
            retries_left_next  = f_retries;
            scanning_next      = f_scanning;
            frames_seen_next   = f_frames;
          end else begin
            window_sum_next = acc;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (fire_frame) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum    <= '0;
      best_sum      <= '0;
      best_position <= '0;
      lens_position <= '0;
      step_size     <= '0;
      retries_left  <= '0;
      scanning      <= 1'b0;
      frames_seen   <= '0;
      out_valid     <= 1'b0;
    end else begin
      window_sum    <= window_sum_next;
      best_sum      <= best_sum_next;
      best_position <= best_position_next;
      lens_position <= lens_position_next;
      step_size     <= step_size_next;
      retries_left  <= retries_left_next;
      scanning      <= scanning_next;
      frames_seen   <= frames_seen_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_frame) begin
      out_data <= {f_scanning, acc, f_lens, lens_position};
    end
  end

  `CAF_ASSERT(a_retries_range, clk, rst, retries_left != 2'd3)
  `CAF_ASSERT(a_no_overwrite, clk, rst, (out_valid && !out_ready) |-> !fire_frame)
  `CAF_ASSERT_NEXT(a_sum_cleared, clk, rst, fire_frame, window_sum == '0)
  `CAF_ASSERT_NEXT(a_cancel_idles, clk, rst, advance && (item.kind == caf_pkg::KIND_CANCEL), !scanning)

endmodule

[dv/contrast_autofocus_hill_climb_tb.sv]
// self-checking testbench for contrast_autofocus_hill_climb
// depends on caf_pkg and the rtl of the block; a local focus predictor or the direct table gives each expected result
`timescale 1ns / 1ps

module contrast_autofocus_hill_climb_tb;

  localparam logic [1:0]  KIND_UNUSED   = 2'd3;
  localparam logic [31:0] CMAX          = 32'hFFFF_FFFF;
  localparam logic [38:0] SUM_SAT       = '1;
  localparam int          SETTLE_CYCLES = 4;
  localparam int          PHASES        = 8;
  localparam int          PHASE_REQS    = 200;
  localparam int          HOLD_CYCLES   = 400;

  typedef struct packed {
    logic signed [11:0] rep_pos;
    logic signed [11:0] nxt_pos;
    logic [38:0]        merit;
    logic               active;
  } focus_res_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  blk;
    logic [31:0] con;
    logic        last;
    logic        typed;
    focus_res_t  want;
  } dir_row_t;

  // default window covers columns 3..8, rows 2..5
  localparam int DIR_N = 22;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{caf_pkg::KIND_SAMPLE, 7'd27,  CMAX,     1'b1, 1'b1,
      '{12'sd0, 12'sd0, 39'h00_FFFF_FFFF, 1'b0}},
    // contrast lost below 0.8 of best starts a scan
    '{caf_pkg::KIND_SAMPLE, 7'd0,   CMAX,     1'b1, 1'b1, '{12'sd0, 12'sd0, 39'd0, 1'b1}},
    '{caf_pkg::KIND_CANCEL, 7'd0,   32'd0,    1'b0, 1'b0, '0},
    '{KIND_UNUSED,          7'd95,  CMAX,     1'b1, 1'b0, '0},
    '{caf_pkg::KIND_SAMPLE, 7'd68,  CMAX,     1'b0, 1'b0, '0},
    '{caf_pkg::KIND_SAMPLE, 7'd69,  CMAX,     1'b0, 1'b0, '0},
    '{caf_pkg::KIND_SAMPLE, 7'd96,  CMAX,     1'b0, 1'b0, '0},
    // out-of-grid block still closes the frame
    '{caf_pkg::KIND_SAMPLE, 7'd127, CMAX,     1'b1, 1'b0, '0},
    '{caf_pkg::KIND_START,  7'd127, CMAX,     1'b1, 1'b0, '0},
    '{caf_pkg::KIND_SAMPLE, 7'd40,  32'd1000, 1'b1, 1'b0, '0},
    '{caf_pkg::KIND_SAMPLE, 7'd40,  32'd2000, 1'b1, 1'b0, '0},
    '{caf_pkg::KIND_SAMPLE, 7'd40,  32'd3000, 1'b1, 1'b0, '0},
    '{caf_pkg::KIND_SAMPLE, 7'd40,  32'd2600, 1'b1, 1'b0, '0},
    '{caf_pkg::KIND_SAMPLE, 7'd41,  32'd0,    1'b0, 1'b0, '0},
    // trigger in mid frame keeps the partial window sum
    '{caf_pkg::KIND_START,  7'd0,   32'd0,    1'b0, 1'b0, '0},
    '{caf_pkg::KIND_SAMPLE, 7'd41,  32'd2900, 1'b1, 1'b0, '0},
    '{caf_pkg::KIND_SAMPLE, 7'd40,  32'd2000, 1'b1, 1'b0, '0},
    '{caf_pkg::KIND_SAMPLE, 7'd40,  32'd1500, 1'b1, 1'b0, '0},
    '{caf_pkg::KIND_CANCEL, 7'd127, CMAX,     1'b1, 1'b0, '0},
    '{caf_pkg::KIND_SAMPLE, 7'd40,  32'd0,    1'b1, 1'b0, '0},
    '{KIND_UNUSED,          7'd0,   32'd0,    1'b0, 1'b0, '0},
    '{caf_pkg::KIND_SAMPLE, 7'd95,  CMAX,     1'b1, 1'b0, '0}
  };

  // fields: left, top, width, height, coarse, fine, startup
  localparam caf_pkg::cfg_t PHASE_CFG [5] = '{
    '{4'd0,  3'd0, 4'd12, 4'd8,  7'd127, 7'd1,   8'd0},
    '{4'd11, 3'd7, 4'd12, 4'd8,  7'd1,   7'd127, 8'd255},
    '{4'd5,  3'd1, 4'd3,  4'd3,  7'd0,   7'd0,   8'd100},
    '{4'd15, 3'd7, 4'd15, 4'd15, 7'd127, 7'd127, 8'd255},
    '{4'd2,  3'd5, 4'd7,  4'd0,  7'd64,  7'd8,   8'd200}
  };

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [39:0] s_tdata  = '0;  // block_index[6:0], contrast[38:7], zero
  logic [1:0]  s_tuser  = '0;  // kind[1:0]
  logic        s_tlast  = 1'b0;
  logic        m_tready = 1'b0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [caf_pkg::PADDR_W-1:0] paddr  = '0;
  logic [31:0]                 pwdata = '0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [63:0] m_tdata;  // reported_position[11:0], new_position[23:12],
                         // figure_of_merit[62:24], scan_active[63]
  wire  [31:0] prdata;
  wire         pready;

  contrast_autofocus_hill_climb dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // focus predictor state
  caf_pkg::cfg_t      cfg = '{4'd3, 3'd2, 4'd6, 4'd4, 7'd31, 7'd4, 8'd30};
  logic [38:0]        win_acc   = '0;
  logic [38:0]        peak_sum  = '0;
  logic signed [11:0] peak_pos  = '0;
  logic signed [11:0] lens      = '0;
  int                 step      = 0;
  int                 retries   = 0;
  bit                 climbing  = 1'b0;
  int                 frame_cnt = 0;

  focus_res_t pending_focus [$];
  int         mismatches = 0;
  int         reqs_sent  = 0;
  bit         quiet_stretch = 1'b0;
  bit         hold_req = 1'b0;

  // contrast profile over lens position
  int          peak_at;
  logic [31:0] peak_level;
  int          slope;

  function automatic void begin_scan();
    peak_sum = '0;
    step     = int'(cfg.coarse_step);
    retries  = 2;
    climbing = 1'b1;
  endfunction

  function automatic bit predict_focus(input logic [1:0] kind, input logic [6:0] idx,
                                       input logic [31:0] con, input logic last,
                                       output focus_res_t res);
    logic [63:0]        wide;
    logic [38:0]        sum;
    logic signed [11:0] was;
    int                 col, row, mag;
    bit                 passed, at_end;
    res = '0;
    if (kind == caf_pkg::KIND_START) begin
      begin_scan();
      return 1'b0;
    end
    if (kind == caf_pkg::KIND_CANCEL) begin
      climbing = 1'b0;
      return 1'b0;
    end
    if (kind != caf_pkg::KIND_SAMPLE) return 1'b0;

    if (int'(idx) < caf_pkg::GRID_BLOCKS) begin
      col = int'(idx) % 12;
      row = int'(idx) / 12;
      if (col >= int'(cfg.win_left) && col < int'(cfg.win_left) + int'(cfg.win_width) &&
          row >= int'(cfg.win_top) && row < int'(cfg.win_top) + int'(cfg.win_height)) begin
        wide    = 64'(win_acc) + 64'(con);
        win_acc = (wide > 64'(SUM_SAT)) ? SUM_SAT : wide[38:0];
      end
    end
    if (!last) return 1'b0;

    sum     = win_acc;
    win_acc = '0;
    was     = lens;
    if (sum >= peak_sum) begin
      peak_sum = sum;
      peak_pos = lens;
    end
    if (climbing) begin
      passed = 1'b0;
      if (64'(sum) * 10 < 64'(peak_sum) * 9) begin
        passed = 1'b1;
      end else begin
        at_end = (step < 0) ? (int'(lens) <= 0) : (int'(lens) >= caf_pkg::MAX_LENS_POS);
        if (at_end) begin
          if (retries <= 1) begin
            retries = 0;
            passed  = 1'b1;
          end else begin
            retries--;
            step = -step;
          end
        end
        if (!passed) lens = 12'(int'(lens) + step);
      end
      if (passed) begin
        mag = (step < 0) ? -step : step;
        if (mag > int'(cfg.fine_step)) begin
          // past the peak: go back around the best point with half the step
          lens     = 12'(int'(peak_pos) + step);
          step     = -(step / 2);
          retries  = 1;
          peak_sum = '0;
        end else begin
          lens     = peak_pos;
          climbing = 1'b0;
        end
      end
    end else if (64'(sum) * 5 < 64'(peak_sum) * 4 ||
                 frame_cnt == int'(cfg.startup_frames)) begin
      begin_scan();
    end
    if (frame_cnt < 511) frame_cnt++;

    res.rep_pos = was;
    res.nxt_pos = lens;
    res.merit   = sum;
    res.active  = climbing;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet_stretch) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] lens_contrast();
    longint v;
    int     d;
    d = int'(lens) - peak_at;
    if (d < 0) d = -d;
    v = longint'(peak_level) - longint'(d) * longint'(slope) +
        longint'($urandom_range(0, peak_level >> 7));
    if (v < 0) v = 0;
    if (v > 64'd4294967295) v = 64'd4294967295;
    return v[31:0];
  endfunction

  task automatic send_req(input logic [1:0] kind, input logic [6:0] idx,
                          input logic [31:0] con, input logic last,
                          input bit typed, input focus_res_t want);
    focus_res_t got;
    bit         has;
    int         gap;
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {1'b0, con, idx};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    has = predict_focus(kind, idx, con, last, got);
    if (has) pending_focus.push_back(typed ? want : got);
    if (kind != KIND_UNUSED) reqs_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_focus.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_cfg(input caf_pkg::cfg_t c);
    apb_write(caf_pkg::REG_WIN_LEFT,       32'(c.win_left));
    apb_write(caf_pkg::REG_WIN_TOP,        32'(c.win_top));
    apb_write(caf_pkg::REG_WIN_WIDTH,      32'(c.win_width));
    apb_write(caf_pkg::REG_WIN_HEIGHT,     32'(c.win_height));
    apb_write(caf_pkg::REG_COARSE_STEP,    32'(c.coarse_step));
    apb_write(caf_pkg::REG_FINE_STEP,      32'(c.fine_step));
    apb_write(caf_pkg::REG_STARTUP_FRAMES, 32'(c.startup_frames));
    cfg = c;
  endtask

  task automatic gen_frame();
    int          r, len, c_lo, c_hi, r_lo, r_hi;
    logic [6:0]  idx;
    logic        last;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 39) == 0) quiet_stretch = !quiet_stretch;
    if (r < 3) begin
      send_req(caf_pkg::KIND_START, 7'($urandom), $urandom, 1'($urandom), 1'b0, '0);
    end else if (r < 5) begin
      send_req(caf_pkg::KIND_CANCEL, 7'($urandom), $urandom, 1'($urandom), 1'b0, '0);
    end else if (r < 6) begin
      send_req(KIND_UNUSED, 7'($urandom), $urandom, 1'($urandom), 1'b0, '0);
    end else if (r < 20) begin
      // noise: any index, any contrast, stray or missing frame ends
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        last = (i == len - 1) ? ($urandom_range(0, 5) != 0) : ($urandom_range(0, 15) == 0);
        send_req(caf_pkg::KIND_SAMPLE, 7'($urandom), $urandom, last, 1'b0, '0);
      end
    end else begin
      len  = $urandom_range(0, 1) ? 1 : $urandom_range(2, 8);
      c_lo = int'(cfg.win_left);
      c_hi = ((c_lo + int'(cfg.win_width) < 12) ? c_lo + int'(cfg.win_width) : 12) - 1;
      r_lo = int'(cfg.win_top);
      r_hi = ((r_lo + int'(cfg.win_height) < 8) ? r_lo + int'(cfg.win_height) : 8) - 1;
      for (int i = 0; i < len; i++) begin
        if (c_lo <= c_hi && r_lo <= r_hi && $urandom_range(0, 9) != 0)
          idx = 7'($urandom_range(r_lo, r_hi) * 12 + $urandom_range(c_lo, c_hi));
        else
          idx = 7'($urandom_range(0, caf_pkg::GRID_BLOCKS - 1));
        send_req(caf_pkg::KIND_SAMPLE, idx, lens_contrast(), i == len - 1, 1'b0, '0);
      end
    end
  endtask

  // result sink with random back-pressure and one long hold-off
  initial begin : sink
    int stall;
    int r;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else if (quiet_stretch) begin
        m_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) stall = $urandom_range(15, 60);
        else if (r < 25) stall = $urandom_range(0, 2);
        m_tready <= (r >= 25);
      end
    end
  end

  always @(posedge clk) begin : check_results
    focus_res_t want;
    focus_res_t seen;
    if (!rst && m_tvalid && m_tready) begin
      seen.rep_pos = m_tdata[11:0];
      seen.nxt_pos = m_tdata[23:12];
      seen.merit   = m_tdata[62:24];
      seen.active  = m_tdata[63];
      if (pending_focus.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected focus result %h", m_tdata);
      end else begin
        want = pending_focus.pop_front();
        if (seen.rep_pos != want.rep_pos || seen.nxt_pos != want.nxt_pos ||
            seen.merit != want.merit || seen.active != want.active) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d->%0d fom %0d act %0b, got %0d->%0d fom %0d act %0b",
                     want.rep_pos, want.nxt_pos, want.merit, want.active,
                     seen.rep_pos, seen.nxt_pos, seen.merit, seen.active);
        end
      end
    end
  end

  initial begin : stimulus
    caf_pkg::cfg_t c;
    int            target;
    bit            held, paused;
    held   = 1'b0;
    paused = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++)
      send_req(DIR_TAB[i].kind, DIR_TAB[i].blk, DIR_TAB[i].con, DIR_TAB[i].last,
               DIR_TAB[i].typed, DIR_TAB[i].want);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      // a trigger request may still be in flight with no result to wait for
      repeat (SETTLE_CYCLES) @(posedge clk);
      if (p < 5) begin
        c = PHASE_CFG[p];
      end else begin
        c.win_left       = 4'($urandom);
        c.win_top        = 3'($urandom);
        c.win_width      = 4'($urandom);
        c.win_height     = 4'($urandom);
        c.coarse_step    = 7'($urandom);
        c.fine_step      = 7'($urandom_range(0, 20));
        c.startup_frames = 8'($urandom);
      end
      write_cfg(c);
      peak_at    = $urandom_range(0, 1300) - 150;
      slope      = $urandom_range(1, 1 << 22);
      peak_level = (p == 0) ? CMAX : $urandom_range(32'h0010_0000, CMAX);
      target     = reqs_sent + PHASE_REQS;
      while (reqs_sent < target) begin
        if (p == 1 && !held && reqs_sent >= target - 120) begin
          hold_req = 1'b1;
          held     = 1'b1;
        end
        if (p == 2 && !paused && reqs_sent >= target - 100) begin
          drain();
          paused = 1'b1;
        end
        gen_frame();
      end
    end

    drain();
    repeat (12) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/caf_pkg.sv
hw/rtl/caf_regs.sv
hw/rtl/caf_blk_in.sv
hw/rtl/caf_climb.sv
hw/rtl/contrast_autofocus_hill_climb.sv
dv/contrast_autofocus_hill_climb_tb.sv
